// File: sv/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is low.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`endif

// File: sv/htre_pkg.sv
// Shared types, codes and defaults of the handle table engine.
package htre_pkg;

	localparam int SLOT_COUNT_DEF    = 64;
	localparam int RESERVED_DEF      = 4;
	localparam int SLOT_FIELD_DEF    = 16;
	localparam int REF_BITS_DEF      = 16;
	localparam int RESOURCE_BITS_DEF = 32;

	// At most this many destroy reports per clear.
	localparam int CLEAR_CAP   = 64;
	localparam int CLEAR_CNT_W = $clog2(CLEAR_CAP);

	typedef enum logic [2:0] {
		OP_ADD     = 3'd0,
		OP_ADD_AT  = 3'd1,
		OP_LOOKUP  = 3'd2,
		OP_ACQUIRE = 3'd3,
		OP_RELEASE = 3'd4,
		OP_CLEAR   = 3'd5
	} opcode_t;

	typedef enum logic [1:0] {
		ST_OK         = 2'd0,
		ST_NO_SLOT    = 2'd1,
		ST_BAD_HANDLE = 2'd2,
		ST_NOT_FOUND  = 2'd3
	} status_t;

	typedef enum logic {
		S_IDLE,
		S_EXEC
	} state_t;

	typedef struct packed {
		logic load;
		logic commit;
	} cmd_t;

	typedef struct packed {
		logic in_known;
		logic out_free;
		logic more;
	} sts_t;

	typedef struct packed {
		status_t     status;
		logic [63:0] handle;
		logic [63:0] etype;
		logic [15:0] caps;
		logic        xfer;
		logic [31:0] res;
		logic [15:0] refs;
		logic        destroy;
		logic        last;
	} result_t;

endpackage

// File: sv/htre_ctrl.sv
// Controller state machine: input handshake and execute sequencing.
module htre_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	output htre_pkg::cmd_t cmd,
	input  htre_pkg::sts_t sts
);
	import htre_pkg::*;

	state_t state_q;
	state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			S_IDLE: begin
				// unused opcodes are taken and dropped without a result
				if (in_valid && sts.in_known) begin
					state_nxt = S_EXEC;
				end
			end
			S_EXEC: begin
				if (sts.out_free && !sts.more) begin
					state_nxt = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	always_comb begin
		in_stall   = 1'b1;
		cmd.load   = 1'b0;
		cmd.commit = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_stall = 1'b0;
				cmd.load = in_valid;
			end
			S_EXEC: begin
				cmd.commit = sts.out_free;
			end
			default: begin
				in_stall = 1'b1;
			end
		endcase
	end

endmodule

// File: sv/htre_dp.sv
// Datapath: occupancy bitmap, entry memory, slot search and result register.
module htre_dp #(
	parameter int SLOT_COUNT      = htre_pkg::SLOT_COUNT_DEF,
	parameter int RESERVED_SLOTS  = htre_pkg::RESERVED_DEF,
	parameter int SLOT_FIELD_BITS = htre_pkg::SLOT_FIELD_DEF,
	parameter int REF_BITS        = htre_pkg::REF_BITS_DEF,
	parameter int RESOURCE_BITS   = htre_pkg::RESOURCE_BITS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  htre_pkg::cmd_t cmd,
	output htre_pkg::sts_t sts,
	input  logic [2:0]     opcode,
	input  logic [63:0]    handle_id,
	input  logic [63:0]    entry_type,
	input  logic [15:0]    entry_caps,
	input  logic           entry_transferable,
	input  logic [31:0]    resource_tag,
	output logic           out_valid,
	input  logic           out_stall,
	output logic [1:0]     status,
	output logic [63:0]    result_handle,
	output logic [63:0]    out_type,
	output logic [15:0]    out_caps,
	output logic           out_transferable,
	output logic [31:0]    out_resource,
	output logic [15:0]    out_refcount,
	output logic           destroy_now,
	output logic           last_result
);
	import htre_pkg::*;

	localparam int SW = $clog2(SLOT_COUNT);
	localparam logic [63:0] SLOT_MASK = (64'd1 << SLOT_FIELD_BITS) - 64'd1;
	localparam logic [REF_BITS-1:0] REF_MAX = '1;

	typedef struct packed {
		logic [63:0]              handle;
		logic [63:0]              etype;
		logic [15:0]              caps;
		logic                     xfer;
		logic [RESOURCE_BITS-1:0] res;
		logic [REF_BITS-1:0]      refs;
	} entry_t;

	function automatic logic [SW-1:0] lowest(input logic [SLOT_COUNT-1:0] v);
		logic [SW-1:0] r;
		r = '0;
		for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
			if (v[i]) begin
				r = SW'(i);
			end
		end
		return r;
	endfunction

	function automatic result_t fill(input entry_t e, input logic destroy, input logic last);
		result_t r;
		r.status  = ST_OK;
		r.handle  = e.handle;
		r.etype   = e.etype;
		r.caps    = e.caps;
		r.xfer    = e.xfer;
		r.res     = 32'(64'(e.res));
		r.refs    = destroy ? 16'd0 : 16'(32'(e.refs));
		r.destroy = destroy;
		r.last    = last;
		return r;
	endfunction

	// item registers
	logic [2:0]   op_q;
	logic [63:0]  h_q;
	logic [63:0]  type_q;
	logic [15:0]  caps_q;
	logic         xfer_q;
	logic [31:0]  tag_q;
	logic         range_q;
	logic [SW-1:0] idx_q;
	entry_t       rd_q;
	logic [SLOT_COUNT-1:0] used_q;
	logic [CLEAR_CNT_W-1:0] clr_cnt_q;
	logic         out_valid_q;
	result_t      out_q;

	entry_t mem [SLOT_COUNT];

	logic [31:0]           in_field;
	logic                  in_range;
	logic [SW-1:0]         in_idx;
	logic                  in_known;
	logic [SLOT_COUNT-1:0] avail;
	logic                  free_any;
	logic [SW-1:0]         free_idx;
	logic [SLOT_COUNT-1:0] remaining;
	logic [SLOT_COUNT-1:0] enc_in;
	logic [SW-1:0]         scan_idx;
	logic                  used_cur;
	logic                  hit;
	logic                  last_clr;
	logic                  clr_empty;
	entry_t                ent_new;
	entry_t                upd;
	result_t               res;
	logic                  we;
	logic [SW-1:0]         waddr;
	entry_t                wdata;
	logic                  set_bit;
	logic                  clr_bit;
	logic                  more;
	logic                  re;
	logic [SW-1:0]         raddr;

	assign in_field = handle_id[31:0] & SLOT_MASK[31:0];
	assign in_range = in_field < 32'(SLOT_COUNT);
	assign in_idx   = in_field[SW-1:0];

	always_comb begin
		case (opcode)
			OP_ADD, OP_ADD_AT, OP_LOOKUP, OP_ACQUIRE, OP_RELEASE, OP_CLEAR: in_known = 1'b1;
			default: in_known = 1'b0;
		endcase
	end

	always_comb begin
		for (int i = 0; i < SLOT_COUNT; i++) begin
			avail[i] = !used_q[i] && (i >= RESERVED_SLOTS);
		end
	end

	assign free_any  = |avail;
	assign free_idx  = lowest(avail);
	assign remaining = used_q & ~(SLOT_COUNT'(1) << idx_q);
	assign enc_in    = cmd.load ? used_q : remaining;
	assign scan_idx  = lowest(enc_in);
	assign used_cur  = range_q && used_q[idx_q];
	assign hit       = used_cur && (rd_q.handle == h_q);
	assign last_clr  = !(|remaining) || (clr_cnt_q == CLEAR_CNT_W'(CLEAR_CAP - 1));
	assign clr_empty = !(|used_q);

	always_comb begin
		ent_new.handle = (op_q == OP_ADD) ? (type_q | (64'(free_idx) & SLOT_MASK)) : h_q;
		ent_new.etype  = type_q;
		ent_new.caps   = caps_q;
		ent_new.xfer   = xfer_q;
		ent_new.res    = RESOURCE_BITS'(64'(tag_q));
		ent_new.refs   = REF_BITS'(1);
	end

	always_comb begin
		res      = '0;
		res.last = 1'b1;
		we       = 1'b0;
		waddr    = idx_q;
		upd      = rd_q;
		wdata    = rd_q;
		set_bit  = 1'b0;
		clr_bit  = 1'b0;
		more     = 1'b0;
		case (op_q)
			OP_ADD: begin
				if (free_any) begin
					we      = 1'b1;
					waddr   = free_idx;
					wdata   = ent_new;
					set_bit = 1'b1;
					res     = fill(ent_new, 1'b0, 1'b1);
				end else begin
					res.status = ST_NO_SLOT;
				end
			end
			OP_ADD_AT: begin
				if (!range_q || used_cur) begin
					res.status = ST_BAD_HANDLE;
				end else begin
					we      = 1'b1;
					wdata   = ent_new;
					set_bit = 1'b1;
					res     = fill(ent_new, 1'b0, 1'b1);
				end
			end
			OP_LOOKUP: begin
				if (hit) begin
					res = fill(rd_q, 1'b0, 1'b1);
				end else begin
					res.status = ST_NOT_FOUND;
				end
			end
			OP_ACQUIRE: begin
				if (hit) begin
					// saturate at the top of the count
					if (rd_q.refs != REF_MAX) begin
						upd.refs = rd_q.refs + REF_BITS'(1);
					end
					we    = 1'b1;
					wdata = upd;
					res   = fill(upd, 1'b0, 1'b1);
				end else begin
					res.status = ST_NOT_FOUND;
				end
			end
			OP_RELEASE: begin
				if (hit) begin
					if (rd_q.refs <= REF_BITS'(1)) begin
						clr_bit = 1'b1;
						res     = fill(rd_q, 1'b1, 1'b1);
					end else begin
						upd.refs = rd_q.refs - REF_BITS'(1);
						we       = 1'b1;
						wdata    = upd;
						res      = fill(upd, 1'b0, 1'b1);
					end
				end else begin
					res.status = ST_NOT_FOUND;
				end
			end
			OP_CLEAR: begin
				// an empty table still gets one plain ok result
				if (!clr_empty) begin
					clr_bit = 1'b1;
					res     = fill(rd_q, 1'b1, last_clr);
					more    = !last_clr;
				end
			end
			default: begin
				res.last = 1'b1;
			end
		endcase
	end

	assign re    = cmd.load || (cmd.commit && more);
	assign raddr = cmd.load ? ((opcode == OP_CLEAR) ? scan_idx : in_idx) : scan_idx;

	always_ff @(posedge clk) begin
		if (cmd.commit && we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rd_q <= mem[raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q    <= opcode;
			h_q     <= handle_id;
			type_q  <= entry_type;
			caps_q  <= entry_caps;
			xfer_q  <= entry_transferable;
			tag_q   <= resource_tag;
			range_q <= in_range;
		end
		if (re) begin
			idx_q <= raddr;
		end
		if (cmd.commit) begin
			out_q <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q      <= '0;
			clr_cnt_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				clr_cnt_q <= '0;
			end else if (cmd.commit) begin
				clr_cnt_q <= clr_cnt_q + CLEAR_CNT_W'(1);
			end
			if (cmd.commit && set_bit) begin
				used_q[waddr] <= 1'b1;
			end
			if (cmd.commit && clr_bit) begin
				used_q[idx_q] <= 1'b0;
			end
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign sts.in_known = in_known;
	assign sts.out_free = !out_valid_q || !out_stall;
	assign sts.more     = more;

	assign out_valid        = out_valid_q;
	assign status           = out_q.status;
	assign result_handle    = out_q.handle;
	assign out_type         = out_q.etype;
	assign out_caps         = out_q.caps;
	assign out_transferable = out_q.xfer;
	assign out_resource     = out_q.res;
	assign out_refcount     = out_q.refs;
	assign destroy_now      = out_q.destroy;
	assign last_result      = out_q.last;

endmodule

// File: sv/handle_table_refcount_engine_unit.sv
// Top level of the handle table engine with reference counts.
//
// Input channel: in_valid/in_stall with opcode, handle_id, entry_type,
// entry_caps, entry_transferable and resource_tag. A transfer happens on a
// rising edge with in_valid high and in_stall low.
// Output channel: out_valid/out_stall with one result per transfer, or one
// destroy report per freed slot for a clear (at most 64, the final one has
// last_result set; an empty table gets one ok result). Opcodes 6 and 7
// are taken and produce nothing. The entry memory read is registered at
// acceptance, and the result register is loaded in the execute state.
// Each operation is accepted, then executed, and no new item is taken
// until it is done; a clear gives one report per cycle unless out_stall
// holds it, set by the single entry memory read port and priority encoder.
// Reset: the occupancy bitmap clears at once and no result is pending; no
// memory sweep is needed since only the contents of occupied slots are used.
// Stall: the output register holds its result; an executing item waits,
// with in_stall high, until the pending result is transferred.
module handle_table_refcount_engine_unit #(
	parameter int SLOT_COUNT      = htre_pkg::SLOT_COUNT_DEF,
	parameter int RESERVED_SLOTS  = htre_pkg::RESERVED_DEF,
	parameter int SLOT_FIELD_BITS = htre_pkg::SLOT_FIELD_DEF,
	parameter int REF_BITS        = htre_pkg::REF_BITS_DEF,
	parameter int RESOURCE_BITS   = htre_pkg::RESOURCE_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  opcode,
	input  logic [63:0] handle_id,
	input  logic [63:0] entry_type,
	input  logic [15:0] entry_caps,
	input  logic        entry_transferable,
	input  logic [31:0] resource_tag,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic [63:0] result_handle,
	output logic [63:0] out_type,
	output logic [15:0] out_caps,
	output logic        out_transferable,
	output logic [31:0] out_resource,
	output logic [15:0] out_refcount,
	output logic        destroy_now,
	output logic        last_result
);
	import htre_pkg::*;

	cmd_t cmd;
	sts_t sts;

	htre_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.cmd      (cmd),
		.sts      (sts)
	);

	htre_dp #(
		.SLOT_COUNT      (SLOT_COUNT),
		.RESERVED_SLOTS  (RESERVED_SLOTS),
		.SLOT_FIELD_BITS (SLOT_FIELD_BITS),
		.REF_BITS        (REF_BITS),
		.RESOURCE_BITS   (RESOURCE_BITS)
	) u_dp (
		.clk                (clk),
		.arst_n             (arst_n),
		.cmd                (cmd),
		.sts                (sts),
		.opcode             (opcode),
		.handle_id          (handle_id),
		.entry_type         (entry_type),
		.entry_caps         (entry_caps),
		.entry_transferable (entry_transferable),
		.resource_tag       (resource_tag),
		.out_valid          (out_valid),
		.out_stall          (out_stall),
		.status             (status),
		.result_handle      (result_handle),
		.out_type           (out_type),
		.out_caps           (out_caps),
		.out_transferable   (out_transferable),
		.out_resource       (out_resource),
		.out_refcount       (out_refcount),
		.destroy_now        (destroy_now),
		.last_result        (last_result)
	);

endmodule

// File: sv/htre_checker.sv
// Port-level checker for the handle table engine, bound to the top level.
`include "assert_macros.svh"

module htre_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic [2:0]  opcode,
	input logic [63:0] handle_id,
	input logic [63:0] entry_type,
	input logic [15:0] entry_caps,
	input logic        entry_transferable,
	input logic [31:0] resource_tag,
	input logic        out_valid,
	input logic        out_stall,
	input logic [1:0]  status,
	input logic [63:0] result_handle,
	input logic [63:0] out_type,
	input logic [15:0] out_caps,
	input logic        out_transferable,
	input logic [31:0] out_resource,
	input logic [15:0] out_refcount,
	input logic        destroy_now,
	input logic        last_result
);
	import htre_pkg::*;

	// hold a stalled result
	`ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(result_handle) && $stable(status) && $stable(last_result))

	// error results carry nothing but the status and end the item
	`ASSERT_IMPLIES(a_err_zero, clk, arst_n, out_valid && (status != ST_OK), (result_handle == 64'd0) && (out_refcount == 16'd0) && !destroy_now && last_result)

	// a destroy report is ok with a zero count
	`ASSERT_IMPLIES(a_destroy_refs, clk, arst_n, out_valid && destroy_now, (status == ST_OK) && (out_refcount == 16'd0))

	// only clear gives more than one result, and each is a destroy
	`ASSERT_IMPLIES(a_mid_destroy, clk, arst_n, out_valid && !last_result, destroy_now)

endmodule

bind handle_table_refcount_engine_unit htre_checker u_htre_checker (.*);
